[rtl/dihedral_angle_four_points_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the dihedral angle block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DIHEDRAL_ANGLE_FOUR_POINTS_MACROS_SVH
`define DIHEDRAL_ANGLE_FOUR_POINTS_MACROS_SVH
`ifndef SYNTHESIS
`define DAFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dafp: same-cycle check failed");
`define DAFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dafp: next-cycle check failed");
`else
`define DAFP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define DAFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/dafp_pkg.sv]
// ----------------------------------------------------------------------------
// Dihedral angle package
// Shared constants, flag bundle and the CORDIC angle table.
// ----------------------------------------------------------------------------
package dafp_pkg;

  localparam int ZFRAC       = 40;   // fraction bits of the angle accumulator
  localparam int ROOT_W      = 63;   // bits of the integer square root
  localparam int SQ_W        = 126;  // bits of the normalized radicand
  localparam int MUL_LAT     = 2;    // pipelined multiplier latency
  localparam int MUL_CHUNK   = 32;   // operand chunk of the multiplier
  localparam int CX_BITS     = 60;   // CORDIC start vector length
  localparam int NSH         = 8;    // right-shift normalize stages
  localparam int NORM_STAGES = 6;    // left-shift normalize stages
  localparam int CORD_W      = 64;   // CORDIC datapath width

  typedef struct packed {
    logic zn;    // a plane normal is the zero vector
    logic tz;    // coplanar points
    logic xneg;  // normals point apart
    logic tneg;  // mirrored side
    logic rot;   // vector was pre-rotated by 90 degrees
  } dafp_flags_t;

  // atan(2^-i) in Q60 from its alternating series
  function automatic logic [63:0] atan_pow2(input int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    logic        sub;
    p   = 64'd1 << (60 - i);
    sum = '0;
    sub = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        term = p / 64'(2 * k + 1);
        sum  = sub ? sum - term : sum + term;
        sub  = !sub;
        p    = p >> (2 * i);
      end
    end
    return sum;
  endfunction

  // pi/4 in Q60 from Machin's formula
  function automatic logic [63:0] atan_q1();
    logic [63:0] p;
    logic [63:0] a5;
    logic [63:0] a239;
    logic        sub;
    p   = (64'd1 << 60) / 64'd5;
    a5  = '0;
    sub = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        a5  = sub ? a5 - p / 64'(2 * k + 1) : a5 + p / 64'(2 * k + 1);
        sub = !sub;
        p   = p / 64'd25;
      end
    end
    p    = (64'd1 << 60) / 64'd239;
    a239 = '0;
    sub  = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        a239 = sub ? a239 - p / 64'(2 * k + 1) : a239 + p / 64'(2 * k + 1);
        sub  = !sub;
        p    = p / 64'd57121;
      end
    end
    return 64'd4 * a5 - a239;
  endfunction

  // CORDIC step angle in degrees, Q24.40
  function automatic logic signed [63:0] atan_tab(input int i);
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] q1;
    if (i == 0) begin
      return 64'sd45 <<< ZFRAC;
    end
    q1  = atan_q1();
    rem = atan_pow2(i);
    q   = '0;
    for (int b = 0; b < ZFRAC; b++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= q1) begin
        rem  = rem - q1;
        q[0] = 1'b1;
      end
    end
    return $signed(64'd45 * q);
  endfunction

endpackage

[rtl/dafp_smul.sv]
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Chunked partial products in the first stage, summed in the second.
// ----------------------------------------------------------------------------
module dafp_smul #(
  parameter int A_W = 33,
  parameter int B_W = 33
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [A_W-1:0]    a,
  input  logic signed [B_W-1:0]    b,
  output logic signed [A_W+B_W-1:0] p
);

  localparam int CK = dafp_pkg::MUL_CHUNK;
  localparam int NA = (A_W + CK - 1) / CK;
  localparam int NB = (B_W + CK - 1) / CK;
  localparam int EW = (NA + NB) * CK;

  logic [NA*CK-1:0]         a_ext;
  logic [NB*CK-1:0]         b_ext;
  logic signed [CK:0]       ca [NA];
  logic signed [CK:0]       cb [NB];
  logic signed [2*CK+1:0]   pp_r [NA][NB];
  logic signed [EW-1:0]     acc;
  logic signed [A_W+B_W-1:0] p_r;

  assign a_ext = (NA*CK)'(a);
  assign b_ext = (NB*CK)'(b);

  // low chunks are unsigned, the top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      ca[i] = $signed({(i == NA - 1) ? a_ext[NA*CK-1] : 1'b0, a_ext[i*CK +: CK]});
    end
    for (int j = 0; j < NB; j++) begin
      cb[j] = $signed({(j == NB - 1) ? b_ext[NB*CK-1] : 1'b0, b_ext[j*CK +: CK]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ca[i] * cb[j];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (EW'(pp_r[i][j]) <<< (CK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[A_W+B_W-1:0];
    end
  end

  assign p = p_r;

endmodule

[rtl/dafp_isqrt.sv]
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring form, floor result.
// ----------------------------------------------------------------------------
module dafp_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [dafp_pkg::SQ_W-1:0]     rad,
  output logic [dafp_pkg::ROOT_W-1:0]   root
);

  localparam int RW  = dafp_pkg::ROOT_W;
  localparam int SW  = dafp_pkg::SQ_W;
  localparam int RMW = RW + 2;

  logic [RMW-1:0] rem_r [RW];
  logic [RW-1:0]  rt_r  [RW];
  logic [SW-1:0]  rd_r  [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RMW-1:0] rem_p;
    logic [RW-1:0]  rt_p;
    logic [SW-1:0]  rd_p;
    logic [RMW+1:0] cur;
    logic [RMW+1:0] trial;

    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign rt_p  = '0;
      assign rd_p  = rad;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign rt_p  = rt_r[k-1];
      assign rd_p  = rd_r[k-1];
    end

    assign cur   = {rem_p, rd_p[SW-1 -: 2]};
    assign trial = (RMW+2)'({rt_p, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (cur >= trial) begin
          rem_r[k] <= RMW'(cur - trial);
          rt_r[k]  <= {rt_p[RW-2:0], 1'b1};
        end else begin
          rem_r[k] <= cur[RMW-1:0];
          rt_r[k]  <= {rt_p[RW-2:0], 1'b0};
        end
      end
    end

    if (k < RW - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en) begin
          rd_r[k] <= rd_p << 2;
        end
      end
    end
  end

  assign root = rt_r[RW-1];

endmodule

[rtl/dihedral_angle_four_points.sv]
// ----------------------------------------------------------------------------
// Dihedral angle of four points
// Streaming torsion angle unit: four Q16.16 points in, degrees out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  carries one beat per point quadruple; in_tdata packs p1_x, p1_y,
//         p1_z, p2_x ... p4_z, COORD_WIDTH bits each, lowest bits first.
//   out_* carries one beat per input beat, in order: out_tdata holds
//         angle_deg (unsigned, ANGLE_FRAC_BITS fraction bits, below 360),
//         out_tuser holds the degenerate flag (a plane normal is zero,
//         angle then reads 0).
//   Throughput is one beat per cycle while out_tready keeps the pipeline
//   moving. Among the stages are 63 square-root, 2 multiply, 1 swap, 8
//   normalize, ANGLE_FRAC_BITS+16 CORDIC and 2 output stages, the square
//   root (one bit per stage) and the CORDIC chain being the longest parts.
//   Reset (rst_n low, synchronous) empties the pipeline; no state is kept
//   between beats. When out_tready is low with a result waiting, the whole
//   pipeline holds and in_tready drops in the same cycle; nothing is lost
//   or repeated, and an empty output slot always lets the input advance.
// ----------------------------------------------------------------------------
`include "dihedral_angle_four_points_macros.svh"

module dihedral_angle_four_points #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0]         in_tdata,
  // angle_deg
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [((ANGLE_FRAC_BITS+9+7)/8)*8-1:0]      out_tdata,
  // degenerate
  output logic [0:0]                                  out_tuser
);

  localparam int CW     = COORD_WIDTH;
  localparam int AFB    = ANGLE_FRAC_BITS;
  localparam int DW     = CW + 1;                 // point difference
  localparam int NW     = 2 * DW + 1;             // normal component
  localparam int XW     = 2 * NW + 2;             // n1.n2
  localparam int TW     = DW + NW + 2;            // d1.n2
  localparam int SW     = 2 * DW + 2;             // d3.d3
  localparam int XSW    = XW + dafp_pkg::SQ_W / 2; // n1.n2 after normalize
  localparam int YW     = TW + dafp_pkg::ROOT_W;  // |t| * root
  localparam int UW     = (XSW > YW) ? XSW : YW;
  localparam int AW     = AFB + 9;
  localparam int OUT_TW = ((AW + 7) / 8) * 8;
  localparam int STEPS  = AFB + 16;
  localparam int SHR    = dafp_pkg::ZFRAC - AFB;
  localparam int NS     = dafp_pkg::NORM_STAGES;
  localparam int NSH    = dafp_pkg::NSH;
  localparam int AT_N   = NS + dafp_pkg::ROOT_W;
  localparam int XD_N   = dafp_pkg::ROOT_W + dafp_pkg::MUL_LAT;
  localparam int FD_N   = NS + dafp_pkg::ROOT_W + dafp_pkg::MUL_LAT;
  localparam int F3_N   = NSH + STEPS + 1;
  localparam int LAT    = 14 + dafp_pkg::ROOT_W + dafp_pkg::MUL_LAT + 1 + NSH + STEPS + 2;

  localparam logic signed [63:0] Z90  = 64'sd90 <<< dafp_pkg::ZFRAC;
  localparam logic signed [63:0] Z360 = 64'sd360 <<< dafp_pkg::ZFRAC;
  localparam logic [63:0]        HALF = 64'd1 << (SHR - 1);
  localparam logic [63:0]        R360 = 64'd360 << AFB;
  localparam logic [AW-1:0]      A180 = AW'(180) << AFB;
  localparam logic [AW:0]        A360 = (AW+1)'(360) << AFB;

  // operand picks for the cross products: x, y, z terms in pairs
  localparam int IA [6] = '{1, 2, 2, 0, 0, 1};
  localparam int IB [6] = '{2, 1, 0, 2, 1, 0};

  logic en;
  logic [LAT-1:0] vld_r;

  // advance everything whenever the output slot is free or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  assign out_tvalid = vld_r[LAT-1];

  // ---------------------------------------------------------------------------
  // Difference vectors from the pivot point
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] pc [12];
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d3_r [3];
  logic signed [DW-1:0] d4_r [3];

  for (genvar k = 0; k < 12; k++) begin : g_unpack
    assign pc[k] = in_tdata[k*CW +: CW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i] <= DW'(pc[i])     - DW'(pc[3+i]);
        d3_r[i] <= DW'(pc[6+i])   - DW'(pc[3+i]);
        d4_r[i] <= DW'(pc[9+i])   - DW'(pc[3+i]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Plane normals n1 = d1 x d3, n2 = d4 x d3
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]   ma [12];
  logic signed [DW-1:0]   mb [12];
  logic signed [2*DW-1:0] pn [12];
  logic signed [NW-1:0]   n_nxt [6];
  logic signed [NW-1:0]   n_r [6];
  logic                   zn_r;
  logic [2:0]             zn_d_r;
  logic [6*DW-1:0]        dd_r [3];
  logic signed [DW-1:0]   d1q [3];
  logic signed [DW-1:0]   d3q [3];

  always_comb begin
    for (int j = 0; j < 6; j++) begin
      ma[j]   = d1_r[IA[j]];
      mb[j]   = d3_r[IB[j]];
      ma[6+j] = d4_r[IA[j]];
      mb[6+j] = d3_r[IB[j]];
    end
  end

  for (genvar k = 0; k < 12; k++) begin : g_nmul
    dafp_smul #(.A_W(DW), .B_W(DW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma[k]),
      .b   (mb[k]),
      .p   (pn[k])
    );
  end

  always_comb begin
    for (int c = 0; c < 6; c++) begin
      n_nxt[c] = NW'(pn[2*c]) - NW'(pn[2*c+1]);
    end
  end

  // hold d1 and d3 alongside the normal products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd_r[0][i*DW +: DW]       <= d1_r[i];
        dd_r[0][(3+i)*DW +: DW]   <= d3_r[i];
      end
      dd_r[1] <= dd_r[0];
      dd_r[2] <= dd_r[1];
      for (int c = 0; c < 6; c++) begin
        n_r[c] <= n_nxt[c];
      end
      zn_r   <= ((n_nxt[0] == '0) && (n_nxt[1] == '0) && (n_nxt[2] == '0)) ||
                ((n_nxt[3] == '0) && (n_nxt[4] == '0) && (n_nxt[5] == '0));
      zn_d_r <= {zn_d_r[1:0], zn_r};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1q[i] = dd_r[2][i*DW +: DW];
      d3q[i] = dd_r[2][(3+i)*DW +: DW];
    end
  end

  // ---------------------------------------------------------------------------
  // Dot products: x = n1.n2, t = d1.n2, s = d3.d3
  // ---------------------------------------------------------------------------
  logic signed [2*NW-1:0]  px [3];
  logic signed [DW+NW-1:0] pt [3];
  logic signed [2*DW-1:0]  ps [3];
  logic signed [XW-1:0]    x_r;
  logic signed [TW-1:0]    t_r;
  logic signed [SW-1:0]    s_r;

  for (genvar c = 0; c < 3; c++) begin : g_dot
    dafp_smul #(.A_W(NW), .B_W(NW)) u_xmul (
      .clk (clk), .en (en), .a (n_r[c]), .b (n_r[3+c]), .p (px[c])
    );
    dafp_smul #(.A_W(DW), .B_W(NW)) u_tmul (
      .clk (clk), .en (en), .a (d1q[c]), .b (n_r[3+c]), .p (pt[c])
    );
    dafp_smul #(.A_W(DW), .B_W(DW)) u_smul (
      .clk (clk), .en (en), .a (d3q[c]), .b (d3q[c]), .p (ps[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= XW'(px[0]) + XW'(px[1]) + XW'(px[2]);
      t_r <= TW'(pt[0]) + TW'(pt[1]) + TW'(pt[2]);
      s_r <= SW'(ps[0]) + SW'(ps[1]) + SW'(ps[2]);
    end
  end

  // ---------------------------------------------------------------------------
  // Prepare: magnitude of t, flags, widen for normalize
  // ---------------------------------------------------------------------------
  logic [TW-1:0]           at_r;
  dafp_pkg::dafp_flags_t   fl_r;
  logic [dafp_pkg::SQ_W-1:0] nss_r [NS+1];
  logic signed [XSW-1:0]   nx_r [NS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      at_r      <= t_r[TW-1] ? TW'(-t_r) : TW'(t_r);
      fl_r.zn   <= zn_d_r[2];
      fl_r.tz   <= (t_r == '0);
      fl_r.xneg <= x_r[XW-1];
      fl_r.tneg <= t_r[TW-1];
      fl_r.rot  <= 1'b0;
      nss_r[0]  <= dafp_pkg::SQ_W'($unsigned(s_r));
      nx_r[0]   <= XSW'(x_r);
    end
  end

  // shift s left by the largest even amount that keeps it below 2^126,
  // and x left by half of it
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int P = 1 << (NS - j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (nss_r[j][dafp_pkg::SQ_W-1 -: P] == '0) begin
          nss_r[j+1] <= nss_r[j] << P;
          nx_r[j+1]  <= nx_r[j] <<< (P / 2);
        end else begin
          nss_r[j+1] <= nss_r[j];
          nx_r[j+1]  <= nx_r[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of |d3|^2 and Y = |t| * root
  // ---------------------------------------------------------------------------
  logic [dafp_pkg::ROOT_W-1:0]              root;
  logic [TW-1:0]                            at_d_r [AT_N];
  logic signed [XSW-1:0]                    x_d_r  [XD_N];
  dafp_pkg::dafp_flags_t                    fl_d_r [FD_N];
  logic signed [TW+dafp_pkg::ROOT_W+1:0]    py;

  dafp_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (nss_r[NS]),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      at_d_r[0] <= at_r;
      for (int k = 1; k < AT_N; k++) at_d_r[k] <= at_d_r[k-1];
      x_d_r[0] <= nx_r[NS];
      for (int k = 1; k < XD_N; k++) x_d_r[k] <= x_d_r[k-1];
      fl_d_r[0] <= fl_r;
      for (int k = 1; k < FD_N; k++) fl_d_r[k] <= fl_d_r[k-1];
    end
  end

  dafp_smul #(.A_W(TW + 1), .B_W(dafp_pkg::ROOT_W + 1)) u_ymul (
    .clk (clk),
    .en  (en),
    .a   ($signed({1'b0, at_d_r[AT_N-1]})),
    .b   ($signed({1'b0, root})),
    .p   (py)
  );

  // ---------------------------------------------------------------------------
  // Fold into the right half plane, then scale to 60 bits
  // ---------------------------------------------------------------------------
  logic signed [XSW-1:0] xl;
  logic [XSW-1:0]        xmag;
  dafp_pkg::dafp_flags_t fs_nxt;
  dafp_pkg::dafp_flags_t f3_r [F3_N];
  logic [UW-1:0]         sbx_r [NSH+1];
  logic [UW-1:0]         sby_r [NSH+1];

  assign xl   = x_d_r[XD_N-1];
  assign xmag = XSW'(-xl);

  always_comb begin
    fs_nxt     = fl_d_r[FD_N-1];
    fs_nxt.rot = xl[XSW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xl[XSW-1]) begin
        sbx_r[0] <= UW'(py[YW-1:0]);
        sby_r[0] <= UW'(xmag);
      end else begin
        sbx_r[0] <= UW'($unsigned(xl));
        sby_r[0] <= UW'(py[YW-1:0]);
      end
      f3_r[0] <= fs_nxt;
      for (int k = 1; k < F3_N; k++) f3_r[k] <= f3_r[k-1];
    end
  end

  // drop low bits until neither value is longer than 60 bits
  for (genvar j = 0; j < NSH; j++) begin : g_shr
    localparam int P = 1 << (NSH - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        if (|((sbx_r[j] | sby_r[j]) >> (dafp_pkg::CX_BITS - 1 + P))) begin
          sbx_r[j+1] <= sbx_r[j] >> P;
          sby_r[j+1] <= sby_r[j] >> P;
        end else begin
          sbx_r[j+1] <= sbx_r[j];
          sby_r[j+1] <= sby_r[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC vectoring: one micro-rotation per stage
  // ---------------------------------------------------------------------------
  localparam int CDW = dafp_pkg::CORD_W;

  logic signed [CDW-1:0] cx0;
  logic signed [CDW-1:0] cy0;
  logic signed [CDW-1:0] cx_r [STEPS];
  logic signed [CDW-1:0] cy_r [STEPS];
  logic signed [CDW-1:0] cz_r [STEPS];

  assign cx0 = CDW'(sbx_r[NSH][dafp_pkg::CX_BITS-1:0]);
  assign cy0 = CDW'(sby_r[NSH][dafp_pkg::CX_BITS-1:0]);

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    localparam logic signed [CDW-1:0] TAB = dafp_pkg::atan_tab(i);
    logic signed [CDW-1:0] xp;
    logic signed [CDW-1:0] yp;
    logic signed [CDW-1:0] zp;

    if (i == 0) begin : g_first
      assign xp = cx0;
      assign yp = cy0;
      assign zp = '0;
    end else begin : g_next
      assign xp = cx_r[i-1];
      assign yp = cy_r[i-1];
      assign zp = cz_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yp > 0) begin
          cx_r[i] <= xp + (yp >>> i);
          cy_r[i] <= yp - (xp >>> i);
          cz_r[i] <= zp + TAB;
        end else begin
          cx_r[i] <= xp - (yp >>> i);
          cy_r[i] <= yp + (xp >>> i);
          cz_r[i] <= zp - TAB;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clamp, unfold, mirror, round and pick the special cases
  // ---------------------------------------------------------------------------
  logic signed [63:0]    zc;
  logic signed [63:0]    phi_nxt;
  logic [63:0]           phi_r;
  dafp_pkg::dafp_flags_t fl4_r;
  logic [63:0]           rnd;
  logic [63:0]           res;
  logic [AW-1:0]         angle_r;
  logic                  deg_r;

  always_comb begin
    zc = cz_r[STEPS-1];
    if (zc < 0) zc = '0;
    if (zc > Z90) zc = Z90;
    phi_nxt = zc + (f3_r[F3_N-1].rot ? Z90 : 64'sd0);
    if (f3_r[F3_N-1].tneg) phi_nxt = Z360 - phi_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r <= $unsigned(phi_nxt);
      fl4_r <= f3_r[F3_N-1];
    end
  end

  always_comb begin
    rnd = (phi_r + HALF) >> SHR;
    res = (rnd >= R360) ? rnd - R360 : rnd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= fl4_r.zn;
      if (fl4_r.zn) begin
        angle_r <= '0;
      end else if (fl4_r.tz) begin
        angle_r <= fl4_r.xneg ? A180 : '0;
      end else begin
        angle_r <= res[AW-1:0];
      end
    end
  end

  assign out_tdata = OUT_TW'(angle_r);
  assign out_tuser = deg_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `DAFP_ASSERT_IMPL(a_deg_zero, clk, rst_n, out_tvalid && out_tuser[0], out_tdata[AW-1:0] == '0)
  `DAFP_ASSERT_IMPL(a_angle_range, clk, rst_n, out_tvalid, {1'b0, out_tdata[AW-1:0]} < A360)
  `DAFP_ASSERT_IMPL(a_ready_empty, clk, rst_n, !out_tvalid, in_tready)
  `DAFP_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_tvalid && in_tready, vld_r[0])

endmodule
